// ===== src/mea_pkg.sv =====
// Shared types and constants for the monomial exponent ALU.
// Defines the request and response transaction structs and the internal stage records.
// No dependencies; every other file refers to it by scoped names.
package mea_pkg;

  // Monomial shape.
  localparam int NUM_VARS = 8;
  localparam int EXP_BITS = 8;
  localparam int WORD_W   = 64;
  localparam int LANES_W  = NUM_VARS * EXP_BITS;
  localparam int LANE_MAX = (1 << EXP_BITS) - 1;
  localparam int DEG_W    = $clog2(NUM_VARS * LANE_MAX + 1);
  localparam int RSP_DEG_W = 11;

  // Operation codes carried in the request.
  typedef enum logic [1:0] {
    MODE_MUL = 2'd0,
    MODE_DIV = 2'd1,
    MODE_GCD = 2'd2,
    MODE_LCM = 2'd3
  } mode_t;

  typedef logic [EXP_BITS-1:0] lane_t;

  // Request transaction.
  typedef struct packed {
    logic [1:0]        mode;
    logic [WORD_W-1:0] a_exps;
    logic [WORD_W-1:0] b_exps;
  } req_t;

  // Response transaction.
  typedef struct packed {
    logic [WORD_W-1:0]    result_exps;
    logic [RSP_DEG_W-1:0] result_degree;
    logic                 a_divisible;
    logic                 equal_flag;
    logic                 a_greater;
    logic                 overflow;
  } rsp_t;

  // Record after the lane stage.
  typedef struct packed {
    lane_t [NUM_VARS-1:0] res;
    lane_t [NUM_VARS-1:0] a;
    lane_t [NUM_VARS-1:0] b;
    logic  [NUM_VARS-1:0] lt;
    logic  [NUM_VARS-1:0] gt;
    logic  [NUM_VARS-1:0] ovf;
  } lane_rec_t;

  // Record after the reduction stage.
  typedef struct packed {
    logic [WORD_W-1:0] result_exps;
    logic [DEG_W-1:0]  res_deg;
    logic [DEG_W-1:0]  deg_a;
    logic [DEG_W-1:0]  deg_b;
    logic              divisible;
    logic              equal;
    logic              tie_greater;
    logic              overflow;
  } red_rec_t;

endpackage

// ===== src/mea_lane.sv =====
// One exponent lane: product, quotient, gcd or lcm of two exponents, plus lane compares.
// Depends on mea_pkg for the lane type and operation codes.
module mea_lane (
  input  logic [1:0]     mode,
  input  mea_pkg::lane_t x,
  input  mea_pkg::lane_t y,
  output mea_pkg::lane_t r,
  output logic           lt,
  output logic           gt,
  output logic           ovf
);

  logic [mea_pkg::EXP_BITS:0] sum;
  logic                       sum_ovf;

  // Product with saturation at the lane maximum.
  assign sum     = {1'b0, x} + {1'b0, y};
  assign sum_ovf = sum[mea_pkg::EXP_BITS];
  assign lt      = (x < y);
  assign gt      = (x > y);

  // Pick the operation; the quotient wraps modulo the lane range.
  always_comb begin
    ovf = 1'b0;
    case (mea_pkg::mode_t'(mode))
      mea_pkg::MODE_MUL: begin
        r   = sum_ovf ? {mea_pkg::EXP_BITS{1'b1}} : sum[mea_pkg::EXP_BITS-1:0];
        ovf = sum_ovf;
      end
      mea_pkg::MODE_DIV: r = x - y;
      mea_pkg::MODE_GCD: r = lt ? x : y;
      mea_pkg::MODE_LCM: r = gt ? x : y;
      default:           r = x;
    endcase
  end

endmodule

// ===== src/mea_reduce.sv =====
// Reduction stage: degree sums, divisibility, equality, overflow and grevlex tie-break.
// Depends on mea_pkg for the stage records.
module mea_reduce (
  input  mea_pkg::lane_rec_t lanes,
  output mea_pkg::red_rec_t  red
);

  always_comb begin
    red = '0;
    // Pack the result lanes; bits above the lanes stay zero.
    for (int i = 0; i < mea_pkg::NUM_VARS; i++) begin
      red.result_exps[i*mea_pkg::EXP_BITS +: mea_pkg::EXP_BITS] = lanes.res[i];
      red.res_deg = red.res_deg + mea_pkg::DEG_W'(lanes.res[i]);
      red.deg_a   = red.deg_a + mea_pkg::DEG_W'(lanes.a[i]);
      red.deg_b   = red.deg_b + mea_pkg::DEG_W'(lanes.b[i]);
    end
    red.divisible = ~|lanes.lt;
    red.equal     = ~|(lanes.lt | lanes.gt);
    red.overflow  = |lanes.ovf;
    // The highest lane that differs decides a degree tie: A wins where B is larger.
    for (int i = 0; i < mea_pkg::NUM_VARS; i++) begin
      if (lanes.lt[i] || lanes.gt[i]) begin
        red.tie_greater = lanes.lt[i];
      end
    end
  end

endmodule

// ===== src/monomial_exponent_alu.sv =====
// Top level of the monomial exponent ALU: three-stage pipeline with valid/ready channels.
// Depends on mea_pkg, mea_lane and mea_reduce.
//
// Usage:
//   The req channel carries one transaction per operand pair (mode, a_exps, b_exps);
//   the rsp channel returns one transaction per request, in order, with the result
//   exponents, their degree and the divisible, equal, grevlex-greater and overflow flags.
//   Stage 1 computes the eight lane operations and compares, stage 2 sums the degrees
//   and reduces the flags, stage 3 does the degree compare and holds the response.
//   An accepted request moves through the lane, reduction and response registers before
//   rsp_valid rises. Throughput is one transaction per cycle while rsp_ready stays high;
//   it is set by the single register per stage.
//   Each stage takes a new transaction when it is empty or when the stage after it
//   moves, so a stalled receiver fills the pipeline up to three transactions before
//   req_ready falls; nothing is dropped or repeated. A bubble in a stage is filled
//   even while the output is stalled.
//   Reset clears all stage valid bits; the block is ready in the cycle after reset.
module monomial_exponent_alu (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  mea_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output mea_pkg::rsp_t rsp
);

  mea_pkg::lane_rec_t lane_next;
  mea_pkg::lane_rec_t lane_q;
  mea_pkg::red_rec_t  red_next;
  mea_pkg::red_rec_t  red_q;
  mea_pkg::rsp_t      rsp_next;
  logic               v1;
  logic               v2;
  logic               v3;
  logic               ready1;
  logic               ready2;
  logic               ready3;

  // Per-stage ready: a stage may load when it is empty or drains this cycle.
  assign ready3    = !v3 || rsp_ready;
  assign ready2    = !v2 || ready3;
  assign ready1    = !v1 || ready2;
  assign req_ready = ready1;
  assign rsp_valid = v3;

  // Stage 1 logic: one lane unit per variable.
  for (genvar g = 0; g < mea_pkg::NUM_VARS; g++) begin : g_lane
    assign lane_next.a[g] = req.a_exps[g*mea_pkg::EXP_BITS +: mea_pkg::EXP_BITS];
    assign lane_next.b[g] = req.b_exps[g*mea_pkg::EXP_BITS +: mea_pkg::EXP_BITS];
    mea_lane u_lane (
      .mode (req.mode),
      .x    (lane_next.a[g]),
      .y    (lane_next.b[g]),
      .r    (lane_next.res[g]),
      .lt   (lane_next.lt[g]),
      .gt   (lane_next.gt[g]),
      .ovf  (lane_next.ovf[g])
    );
  end

  // Stage 2 logic: reductions over the lanes.
  mea_reduce u_reduce (
    .lanes (lane_q),
    .red   (red_next)
  );

  // Stage 3 logic: grevlex decision and response packing.
  always_comb begin
    rsp_next.result_exps   = red_q.result_exps;
    rsp_next.result_degree = mea_pkg::RSP_DEG_W'(red_q.res_deg);
    rsp_next.a_divisible   = red_q.divisible;
    rsp_next.equal_flag    = red_q.equal;
    rsp_next.a_greater     = (red_q.deg_a > red_q.deg_b) ||
                             ((red_q.deg_a == red_q.deg_b) && red_q.tie_greater);
    rsp_next.overflow      = red_q.overflow;
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= req_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (ready1 && req_valid) lane_q <= lane_next;
    if (ready2 && v1)        red_q  <= red_next;
    if (ready3 && v2)        rsp    <= rsp_next;
  end

endmodule

// ===== src/mea_checker.sv =====
// Port-level checker for the monomial exponent ALU, bound to the top level.
// Depends on mea_pkg for the response transaction type.
module mea_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input mea_pkg::rsp_t rsp,
  input logic          rsp_valid,
  input logic          rsp_ready
);

  // A stalled response keeps its valid and its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // No response transaction is shown right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // A request is taken whenever the output side is free to move.
  a_req_taken: assert property (@(posedge clk) disable iff (rst)
    req_valid && (!rsp_valid || rsp_ready) |-> req_ready)
    else $error("request refused while the pipeline can advance");

  // Equal monomials divide each other and neither is greater.
  a_equal_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.equal_flag |-> rsp.a_divisible && !rsp.a_greater)
    else $error("equal monomials with inconsistent flags");

  // A proper multiple of B has the higher degree, so it is greater.
  a_multiple_greater: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.a_divisible && !rsp.equal_flag |-> rsp.a_greater)
    else $error("proper multiple not ordered above divisor");

endmodule

bind monomial_exponent_alu mea_checker u_mea_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp       (rsp),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready)
);

// ===== sim/tb_monomial_exponent_alu.sv =====
// Self-checking testbench for monomial_exponent_alu: directed table, then random operand pairs.
// Each response is checked against a hand-written expectation or an in-bench grevlex/exponent predictor.
// Depends on mea_pkg and the monomial_exponent_alu RTL.
`timescale 1ns / 100ps

module tb_monomial_exponent_alu;

  localparam int RANDOM_ITEMS = 1250;
  localparam int CALM_ITEMS   = 150;

  // One line of the directed table; known_rsp is used only when known is set.
  typedef struct {
    mea_pkg::req_t item;
    bit            known;
    mea_pkg::rsp_t known_rsp;
  } stim_row_t;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  mea_pkg::req_t  req       = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  mea_pkg::rsp_t  rsp;

  mea_pkg::rsp_t expected_rsps[$];
  stim_row_t     directed_rows[$];
  int            mismatches = 0;
  int            idle_pct   = 0;
  int            stall_left = 0;

  monomial_exponent_alu dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Expected response: lane operation, degree sum, flags and grevlex comparison.
  function automatic mea_pkg::rsp_t grevlex_alu_predict(mea_pkg::req_t r);
    mea_pkg::rsp_t               o;
    mea_pkg::lane_t              x;
    mea_pkg::lane_t              y;
    mea_pkg::lane_t              res_lane;
    logic [mea_pkg::EXP_BITS:0]  wide;
    int unsigned                 res_deg;
    int unsigned                 deg_a;
    int unsigned                 deg_b;
    bit                          decided;
    o = '0;
    o.a_divisible = 1'b1;
    o.equal_flag  = 1'b1;
    res_deg = 0;
    deg_a   = 0;
    deg_b   = 0;
    decided = 1'b0;
    for (int i = 0; i < mea_pkg::NUM_VARS; i++) begin
      x = r.a_exps[i*mea_pkg::EXP_BITS +: mea_pkg::EXP_BITS];
      y = r.b_exps[i*mea_pkg::EXP_BITS +: mea_pkg::EXP_BITS];
      deg_a += x;
      deg_b += y;
      if (x < y) o.a_divisible = 1'b0;
      if (x != y) o.equal_flag = 1'b0;
      case (r.mode)
        mea_pkg::MODE_MUL: begin
          wide = x + y;
          if (wide > mea_pkg::LANE_MAX) begin
            res_lane   = mea_pkg::lane_t'(mea_pkg::LANE_MAX);
            o.overflow = 1'b1;
          end else begin
            res_lane = wide[mea_pkg::EXP_BITS-1:0];
          end
        end
        mea_pkg::MODE_DIV: res_lane = x - y;
        mea_pkg::MODE_GCD: res_lane = (x < y) ? x : y;
        default:           res_lane = (x > y) ? x : y;
      endcase
      o.result_exps[i*mea_pkg::EXP_BITS +: mea_pkg::EXP_BITS] = res_lane;
      res_deg += res_lane;
    end
    o.result_degree = res_deg[mea_pkg::RSP_DEG_W-1:0];
    // Higher degree wins; on a tie the last differing variable decides, smaller in A wins.
    if (deg_a > deg_b) begin
      o.a_greater = 1'b1;
    end else if (deg_a == deg_b) begin
      for (int i = mea_pkg::NUM_VARS - 1; i >= 0 && !decided; i--) begin
        x = r.a_exps[i*mea_pkg::EXP_BITS +: mea_pkg::EXP_BITS];
        y = r.b_exps[i*mea_pkg::EXP_BITS +: mea_pkg::EXP_BITS];
        if (y > x) begin
          o.a_greater = 1'b1;
          decided     = 1'b1;
        end else if (x > y) begin
          decided = 1'b1;
        end
      end
    end
    return o;
  endfunction

  // Table row whose response comes from the predictor.
  function automatic stim_row_t row_free(mea_pkg::mode_t m, logic [mea_pkg::WORD_W-1:0] a,
                                         logic [mea_pkg::WORD_W-1:0] b);
    stim_row_t s;
    s.item.mode   = m;
    s.item.a_exps = a;
    s.item.b_exps = b;
    s.known       = 1'b0;
    s.known_rsp   = '0;
    return s;
  endfunction

  // Table row with its response written out by hand.
  function automatic stim_row_t row_known(mea_pkg::mode_t m, logic [mea_pkg::WORD_W-1:0] a,
                                          logic [mea_pkg::WORD_W-1:0] b,
                                          logic [mea_pkg::WORD_W-1:0] res,
                                          int deg, bit div, bit eq, bit gt, bit ovf);
    stim_row_t s;
    s = row_free(m, a, b);
    s.known                   = 1'b1;
    s.known_rsp.result_exps   = res;
    s.known_rsp.result_degree = deg[mea_pkg::RSP_DEG_W-1:0];
    s.known_rsp.a_divisible   = div;
    s.known_rsp.equal_flag    = eq;
    s.known_rsp.a_greater     = gt;
    s.known_rsp.overflow      = ovf;
    return s;
  endfunction

  // Add one row at the end of the directed table.
  function automatic void append_row(stim_row_t s);
    directed_rows = {directed_rows, s};
  endfunction

  // Random operand pair, biased toward saturation, divisibility and degree ties.
  function automatic mea_pkg::req_t random_req();
    mea_pkg::req_t  r;
    int             p;
    int             q;
    mea_pkg::lane_t tmp;
    r.mode   = 2'($urandom_range(0, 3));
    r.a_exps = {$urandom(), $urandom()};
    r.b_exps = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      2: begin
        for (int i = 0; i < mea_pkg::NUM_VARS; i++) begin
          r.a_exps[i*mea_pkg::EXP_BITS +: mea_pkg::EXP_BITS] =
            mea_pkg::lane_t'($urandom_range(0, 3));
          r.b_exps[i*mea_pkg::EXP_BITS +: mea_pkg::EXP_BITS] =
            mea_pkg::lane_t'($urandom_range(0, 3));
        end
      end
      3: begin
        for (int i = 0; i < mea_pkg::NUM_VARS; i++) begin
          r.a_exps[i*mea_pkg::EXP_BITS +: mea_pkg::EXP_BITS] =
            mea_pkg::lane_t'($urandom_range(200, 255));
        end
      end
      4: r.b_exps = r.a_exps;
      5: begin
        for (int i = 0; i < mea_pkg::NUM_VARS; i++) begin
          r.b_exps[i*mea_pkg::EXP_BITS +: mea_pkg::EXP_BITS] = mea_pkg::lane_t'(
            $urandom_range(0, r.a_exps[i*mea_pkg::EXP_BITS +: mea_pkg::EXP_BITS]));
        end
      end
      6: begin
        // Two lanes swapped keeps the degree equal, so the tie-break scan decides.
        p = $urandom_range(0, mea_pkg::NUM_VARS - 1);
        q = $urandom_range(0, mea_pkg::NUM_VARS - 1);
        r.b_exps = r.a_exps;
        tmp = r.b_exps[p*mea_pkg::EXP_BITS +: mea_pkg::EXP_BITS];
        r.b_exps[p*mea_pkg::EXP_BITS +: mea_pkg::EXP_BITS] =
          r.b_exps[q*mea_pkg::EXP_BITS +: mea_pkg::EXP_BITS];
        r.b_exps[q*mea_pkg::EXP_BITS +: mea_pkg::EXP_BITS] = tmp;
      end
      7: r.b_exps = {r.a_exps[mea_pkg::WORD_W-mea_pkg::EXP_BITS-1:0],
                     r.a_exps[mea_pkg::WORD_W-1 -: mea_pkg::EXP_BITS]};
      default: ;
    endcase
    return r;
  endfunction

  // Present one request transaction, optionally after an idle burst, and record its expected response.
  task automatic issue_request(input mea_pkg::req_t item, input bit known,
                               input mea_pkg::rsp_t known_rsp);
    int            gap;
    mea_pkg::rsp_t want;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 15);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    want = known ? known_rsp : grevlex_alu_predict(item);
    expected_rsps = {expected_rsps, want};
  endtask

  function automatic void check_field(string name, logic [mea_pkg::WORD_W-1:0] want,
                                      logic [mea_pkg::WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare one response transaction with the oldest expectation.
  function automatic void check_response(mea_pkg::rsp_t got);
    mea_pkg::rsp_t want;
    if (expected_rsps.size() == 0) begin
      $error("response with no request outstanding: %h", got);
      mismatches++;
    end else begin
      want = expected_rsps.pop_front();
      check_field("result_exps", want.result_exps, got.result_exps);
      check_field("result_degree", mea_pkg::WORD_W'(want.result_degree),
                  mea_pkg::WORD_W'(got.result_degree));
      check_field("a_divisible", mea_pkg::WORD_W'(want.a_divisible),
                  mea_pkg::WORD_W'(got.a_divisible));
      check_field("equal_flag", mea_pkg::WORD_W'(want.equal_flag),
                  mea_pkg::WORD_W'(got.equal_flag));
      check_field("a_greater", mea_pkg::WORD_W'(want.a_greater),
                  mea_pkg::WORD_W'(got.a_greater));
      check_field("overflow", mea_pkg::WORD_W'(want.overflow),
                  mea_pkg::WORD_W'(got.overflow));
    end
  endfunction

  // Response side: check accepted transactions and stall in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_valid && rsp_ready) check_response(rsp);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 4) begin
        stall_left = $urandom_range(1, 15) - 1;
        rsp_ready  <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Zero and all-ones operands in every mode.
    append_row(row_known(mea_pkg::MODE_MUL, '0, '0, '0, 0, 1, 1, 0, 0));
    append_row(row_known(mea_pkg::MODE_MUL, '1, '1, '1, 2040, 1, 1, 0, 1));
    append_row(row_known(mea_pkg::MODE_DIV, '1, '1, '0, 0, 1, 1, 0, 0));
    append_row(row_known(mea_pkg::MODE_GCD, '1, '0, '0, 0, 1, 0, 1, 0));
    append_row(row_known(mea_pkg::MODE_LCM, '1, '0, '1, 2040, 1, 0, 1, 0));
    // Quotient that wraps in every lane.
    append_row(row_known(mea_pkg::MODE_DIV, '0, '1, 64'h0101_0101_0101_0101, 8,
                         0, 0, 0, 0));
    // Product exactly one over the lane maximum, and exactly at it.
    append_row(row_known(mea_pkg::MODE_MUL, 64'h8080_8080_8080_8080,
                         64'h8080_8080_8080_8080, '1, 2040, 1, 1, 0, 1));
    append_row(row_known(mea_pkg::MODE_MUL, 64'h7F7F_7F7F_7F7F_7F7F,
                         64'h8080_8080_8080_8080, '1, 2040, 0, 0, 0, 0));
    // Saturation in a single lane, at the low and the high end.
    append_row(row_free(mea_pkg::MODE_MUL, 64'h0000_0000_0000_00FF, 64'h0000_0000_0000_0001));
    append_row(row_free(mea_pkg::MODE_MUL, 64'hC000_0000_0000_0010, 64'h4000_0000_0000_0020));
    // Overflow-capable operands in division, then complementary patterns in gcd, lcm and product.
    append_row(row_free(mea_pkg::MODE_DIV, 64'hC000_0000_0000_0010, 64'h4000_0000_0000_0020));
    append_row(row_free(mea_pkg::MODE_GCD, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555));
    append_row(row_free(mea_pkg::MODE_LCM, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555));
    append_row(row_free(mea_pkg::MODE_MUL, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
    // Degree ties decided in the second-lowest and the highest variable.
    append_row(row_free(mea_pkg::MODE_LCM, 64'h0000_0000_0000_0100, 64'h0000_0000_0000_0001));
    append_row(row_free(mea_pkg::MODE_LCM, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_0100));
    append_row(row_free(mea_pkg::MODE_GCD, 64'h0100_0000_0000_0000, 64'h0000_0000_0000_0001));
    append_row(row_free(mea_pkg::MODE_GCD, 64'h0000_0000_0000_0001, 64'h0100_0000_0000_0000));
    // Degree decides before the scan does.
    append_row(row_free(mea_pkg::MODE_MUL, 64'h0000_0000_0000_0003, 64'h0100_0000_0000_0001));
    // Exact quotient and a near miss, then gcd and lcm of two mirrored operands.
    append_row(row_free(mea_pkg::MODE_DIV, 64'h0807_0605_0403_0201, 64'h0403_0201_0403_0201));
    append_row(row_free(mea_pkg::MODE_DIV, 64'h0807_0605_0403_0201, 64'h0403_0201_0403_0202));
    append_row(row_free(mea_pkg::MODE_GCD, 64'h0807_0605_0403_0201, 64'h0102_0304_0506_0708));
    append_row(row_free(mea_pkg::MODE_LCM, 64'h0807_0605_0403_0201, 64'h0102_0304_0506_0708));

    foreach (directed_rows[k]) begin
      issue_request(directed_rows[k].item, directed_rows[k].known, directed_rows[k].known_rsp);
    end

    // Random phase: idle level changes every hundred transactions, none at the end.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 50;
        endcase
      end
      if (n >= RANDOM_ITEMS - CALM_ITEMS) idle_pct = 0;
      issue_request(random_req(), 1'b0, '0);
    end
    req_valid <= 1'b0;

    // Drain, then give the pipeline time to show any stray response.
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
src/mea_pkg.sv
src/mea_lane.sv
src/mea_reduce.sv
src/monomial_exponent_alu.sv
src/mea_checker.sv
sim/tb_monomial_exponent_alu.sv
